// ----- src/two_circle_relation_classifier_assert.svh -----
// Assertion macros for the two-circle relation classifier.
// Included by the top level; depends on nothing else.
`ifndef TWO_CIRCLE_RELATION_CLASSIFIER_ASSERT_SVH
`define TWO_CIRCLE_RELATION_CLASSIFIER_ASSERT_SVH
`ifndef SYNTHESIS
`define TCRC_ASSERT_NOW(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);
`define TCRC_ASSERT_NEXT(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);
`else
`define TCRC_ASSERT_NOW(label, clk, rst, a, c, msg)
`define TCRC_ASSERT_NEXT(label, clk, rst, a, c, msg)
`endif
`endif

// ----- src/tcrc_pkg.sv -----
// Widths, relation codes and pipeline payload types for the
// two-circle relation classifier. No dependencies.
`default_nettype none
package tcrc_pkg;

  localparam int CW    = 16;
  localparam int CTR_W = CW + 1;
  localparam int SQ_W  = 2 * CW + 1;
  localparam int R_W   = 2 * CW;
  localparam int S_W   = 2 * CW + 3;
  localparam int X_W   = 2 * CW + 2;
  localparam int XH_W  = X_W / 2;
  localparam int P_W   = 2 * X_W;
  localparam int REL_W = 3;

  localparam logic [REL_W-1:0] REL_CONCENTRIC  = 3'd0;
  localparam logic [REL_W-1:0] REL_INT_TANGENT = 3'd1;
  localparam logic [REL_W-1:0] REL_INSIDE      = 3'd2;
  localparam logic [REL_W-1:0] REL_TWO_POINTS  = 3'd3;
  localparam logic [REL_W-1:0] REL_EXT_TANGENT = 3'd4;
  localparam logic [REL_W-1:0] REL_SEPARATE    = 3'd5;
  localparam logic [REL_W-1:0] REL_INVALID     = 3'd6;

  typedef struct packed {
    logic signed [CTR_W-1:0] c1x;
    logic signed [CTR_W-1:0] c1y;
    logic signed [CTR_W-1:0] c2x;
    logic signed [CTR_W-1:0] c2y;
  } ctr_t;

  typedef struct packed {
    logic signed [SQ_W-1:0] r1;
    logic signed [SQ_W-1:0] r2;
    logic [SQ_W-1:0]        d;
  } res_t;

  typedef struct packed {
    logic invalid;
    logic conc;
    logic s_neg;
  } cls_t;

endpackage
`default_nettype wire

// ----- src/tcrc_sqprod.sv -----
// Two-stage unit forming x*x from split partial products and 4*r1*r2 from one full product.
// Depends on tcrc_pkg.
`default_nettype none
module tcrc_sqprod
  import tcrc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [X_W-1:0]   x,
  input  logic [R_W-1:0]   r1,
  input  logic [R_W-1:0]   r2,
  output logic             out_valid,
  output logic [P_W-1:0]   xsq,
  output logic [P_W-1:0]   prod
);

  logic [XH_W-1:0]   xh;
  logic [XH_W-1:0]   xl;
  logic              v4;
  logic [2*XH_W-1:0] hh;
  logic [2*XH_W-1:0] hl;
  logic [2*XH_W-1:0] ll;
  logic [2*R_W-1:0]  rr;

  assign xh = x[X_W-1:XH_W];
  assign xl = x[XH_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v4        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v4        <= in_valid;
      out_valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    hh   <= (2*XH_W)'(xh) * (2*XH_W)'(xh);
    hl   <= (2*XH_W)'(xh) * (2*XH_W)'(xl);
    ll   <= (2*XH_W)'(xl) * (2*XH_W)'(xl);
    rr   <= (2*R_W)'(r1) * (2*R_W)'(r2);
    xsq  <= (P_W'(hh) << X_W) + (P_W'(hl) << (XH_W + 1)) + P_W'(ll);
    prod <= P_W'(rr) << 2;
  end

endmodule
`default_nettype wire

// ----- src/two_circle_relation_classifier.sv -----
// Top level: classifies how two circles given by x^2+y^2+Ax+By+C=0 lie.
// Depends on tcrc_pkg, tcrc_sqprod and the assertion macro header.
//
//   channel  | handshake     | payload
//   ---------+---------------+------------------------------------------------
//   input    | start / busy  | coef_a1 coef_b1 coef_c1 coef_a2 coef_b2 coef_c2
//   result   | done          | relation centre1_x/y centre2_x/y radius1_sq
//            |               | radius2_sq distance_sq
//
// Seven register stages; one pair enters every cycle and its result shows on
// done, in the order the pairs went in. busy is always low: the squaring
// and the 32x32 radius product are split over two stages of tcrc_sqprod.
// Reset clears only the valid bits; the result side cannot stall.
`default_nettype none
`include "two_circle_relation_classifier_assert.svh"
module two_circle_relation_classifier
  import tcrc_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic signed [CW-1:0]    coef_a1,
  input  logic signed [CW-1:0]    coef_b1,
  input  logic signed [CW-1:0]    coef_c1,
  input  logic signed [CW-1:0]    coef_a2,
  input  logic signed [CW-1:0]    coef_b2,
  input  logic signed [CW-1:0]    coef_c2,
  output logic                    done,
  output logic [REL_W-1:0]        relation,
  output logic signed [CTR_W-1:0] centre1_x,
  output logic signed [CTR_W-1:0] centre1_y,
  output logic signed [CTR_W-1:0] centre2_x,
  output logic signed [CTR_W-1:0] centre2_y,
  output logic signed [SQ_W-1:0]  radius1_sq,
  output logic signed [SQ_W-1:0]  radius2_sq,
  output logic [SQ_W-1:0]         distance_sq
);

  logic [3:0]              vld;
  logic                    v5;
  ctr_t                    ctr_q [0:5];
  res_t                    res_q [2:5];
  cls_t                    cls_q [3:5];

  logic signed [CW-1:0]    a1_0, b1_0, c1_0, a2_0, b2_0, c2_0;
  logic signed [CTR_W-1:0] dx0, dy0;
  logic [R_W-1:0]          a1sq1, b1sq1, a2sq1, b2sq1, dxsq1, dysq1;
  logic signed [CW-1:0]    c1_1, c2_1;
  logic signed [S_W-1:0]   s_full, t_full;
  logic [X_W-1:0]          x3;
  logic [P_W-1:0]          xsq5, prod5;
  logic [REL_W-1:0]        rel_next;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= '0;
      done <= 1'b0;
    end else begin
      vld  <= {vld[2:0], start};
      done <= v5;
    end
  end

  // stage 0: capture, negate centres, take coordinate differences
  always_ff @(posedge clk) begin
    a1_0 <= coef_a1;
    b1_0 <= coef_b1;
    c1_0 <= coef_c1;
    a2_0 <= coef_a2;
    b2_0 <= coef_b2;
    c2_0 <= coef_c2;
    dx0  <= CTR_W'(coef_a2) - CTR_W'(coef_a1);
    dy0  <= CTR_W'(coef_b2) - CTR_W'(coef_b1);
    ctr_q[0].c1x <= -CTR_W'(coef_a1);
    ctr_q[0].c1y <= -CTR_W'(coef_b1);
    ctr_q[0].c2x <= -CTR_W'(coef_a2);
    ctr_q[0].c2y <= -CTR_W'(coef_b2);
    for (int k = 1; k < 6; k++) begin
      ctr_q[k] <= ctr_q[k-1];
    end
  end

  // stage 1: squares
  always_ff @(posedge clk) begin
    a1sq1 <= R_W'(a1_0) * R_W'(a1_0);
    b1sq1 <= R_W'(b1_0) * R_W'(b1_0);
    a2sq1 <= R_W'(a2_0) * R_W'(a2_0);
    b2sq1 <= R_W'(b2_0) * R_W'(b2_0);
    dxsq1 <= R_W'(dx0) * R_W'(dx0);
    dysq1 <= R_W'(dy0) * R_W'(dy0);
    c1_1  <= c1_0;
    c2_1  <= c2_0;
  end

  // stage 2: squared radii and squared distance
  always_ff @(posedge clk) begin
    res_q[2].r1 <= $signed(SQ_W'(a1sq1)) + $signed(SQ_W'(b1sq1)) - (SQ_W'(c1_1) <<< 2);
    res_q[2].r2 <= $signed(SQ_W'(a2sq1)) + $signed(SQ_W'(b2sq1)) - (SQ_W'(c2_1) <<< 2);
    res_q[2].d  <= SQ_W'(dxsq1) + SQ_W'(dysq1);
    for (int k = 3; k < 6; k++) begin
      res_q[k] <= res_q[k-1];
    end
  end

  // stage 3: signed gap between radius sum and distance, its magnitude; invalid, concentric and sign flags
  assign s_full = S_W'(res_q[2].r1) + S_W'(res_q[2].r2) - $signed(S_W'(res_q[2].d));
  assign t_full = $signed(S_W'(res_q[2].d)) - S_W'(res_q[2].r1) - S_W'(res_q[2].r2);

  always_ff @(posedge clk) begin
    x3               <= s_full[S_W-1] ? t_full[X_W-1:0] : s_full[X_W-1:0];
    cls_q[3].invalid <= res_q[2].r1[SQ_W-1] | res_q[2].r2[SQ_W-1];
    cls_q[3].conc    <= (res_q[2].d == '0);
    cls_q[3].s_neg   <= s_full[S_W-1];
    cls_q[4]         <= cls_q[3];
    cls_q[5]         <= cls_q[4];
  end

  // stages 4 and 5
  tcrc_sqprod u_sqprod (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (vld[3]),
    .x         (x3),
    .r1        (res_q[3].r1[R_W-1:0]),
    .r2        (res_q[3].r2[R_W-1:0]),
    .out_valid (v5),
    .xsq       (xsq5),
    .prod      (prod5)
  );

  // stage 6: compare and classify
  always_comb begin
    if (cls_q[5].invalid) begin
      rel_next = REL_INVALID;
    end else if (cls_q[5].conc) begin
      rel_next = REL_CONCENTRIC;
    end else if (!cls_q[5].s_neg) begin
      if (xsq5 == prod5) begin
        rel_next = REL_INT_TANGENT;
      end else if (xsq5 > prod5) begin
        rel_next = REL_INSIDE;
      end else begin
        rel_next = REL_TWO_POINTS;
      end
    end else begin
      if (xsq5 < prod5) begin
        rel_next = REL_TWO_POINTS;
      end else if (xsq5 == prod5) begin
        rel_next = REL_EXT_TANGENT;
      end else begin
        rel_next = REL_SEPARATE;
      end
    end
  end

  always_ff @(posedge clk) begin
    relation    <= rel_next;
    centre1_x   <= ctr_q[5].c1x;
    centre1_y   <= ctr_q[5].c1y;
    centre2_x   <= ctr_q[5].c2x;
    centre2_y   <= ctr_q[5].c2y;
    radius1_sq  <= res_q[5].r1;
    radius2_sq  <= res_q[5].r2;
    distance_sq <= res_q[5].d;
  end

  `TCRC_ASSERT_NOW(a_done_has_start, clk, rst, done, $past(start, 7), "result without a start transfer")
  `TCRC_ASSERT_NOW(a_invalid_sign, clk, rst, done, ((relation == REL_INVALID) == (radius1_sq[SQ_W-1] | radius2_sq[SQ_W-1])), "invalid code disagrees with radius sign")
  `TCRC_ASSERT_NOW(a_concentric_dist, clk, rst, done && (relation == REL_CONCENTRIC), (distance_sq == '0), "concentric with nonzero distance")

endmodule
`default_nettype wire

// ----- sim/tb_two_circle_relation_classifier.sv -----
// Testbench for two_circle_relation_classifier: drives circle pairs through start/busy
// and checks every done result field by field against a local classifier.
// Depends on tcrc_pkg and the two_circle_relation_classifier RTL.
module tb_two_circle_relation_classifier
  import tcrc_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT = 2000;
  localparam int RANDOM_PAIRS = 1250;
  localparam int TAIL_CYCLES = 20;

  typedef struct {
    logic signed [CW-1:0] a1, b1, c1, a2, b2, c2;
    bit drain_first;
  } circle_pair_t;

  typedef struct {
    logic [REL_W-1:0] rel;
    logic signed [CTR_W-1:0] c1x, c1y, c2x, c2y;
    logic signed [SQ_W-1:0] r1, r2;
    logic [SQ_W-1:0] d;
  } relation_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic signed [CW-1:0] coef_a1 = '0;
  logic signed [CW-1:0] coef_b1 = '0;
  logic signed [CW-1:0] coef_c1 = '0;
  logic signed [CW-1:0] coef_a2 = '0;
  logic signed [CW-1:0] coef_b2 = '0;
  logic signed [CW-1:0] coef_c2 = '0;
  logic busy;
  logic done;
  logic [REL_W-1:0] relation;
  logic signed [CTR_W-1:0] centre1_x, centre1_y, centre2_x, centre2_y;
  logic signed [SQ_W-1:0] radius1_sq, radius2_sq;
  logic [SQ_W-1:0] distance_sq;

  circle_pair_t pending_pairs[$];
  circle_pair_t next_pair;
  relation_result_t expected_relations[$];
  relation_result_t oldest_relation;
  int idle_pcts[4] = '{0, 65, 0, 24};
  int pairs_sent = 0;
  int quiet_cycles = 0;
  int errors = 0;

  two_circle_relation_classifier dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .coef_a1(coef_a1),
    .coef_b1(coef_b1),
    .coef_c1(coef_c1),
    .coef_a2(coef_a2),
    .coef_b2(coef_b2),
    .coef_c2(coef_c2),
    .done(done),
    .relation(relation),
    .centre1_x(centre1_x),
    .centre1_y(centre1_y),
    .centre2_x(centre2_x),
    .centre2_y(centre2_y),
    .radius1_sq(radius1_sq),
    .radius2_sq(radius2_sq),
    .distance_sq(distance_sq)
  );

  always #5 clk = ~clk;

  // sign of x*x - 4*ra*rb, all arguments nonnegative
  function automatic int compare_square(input longint x, input longint ra, input longint rb);
    logic [127:0] lhs;
    logic [127:0] rhs;
    lhs = 128'(x) * 128'(x);
    rhs = 128'(ra) * 128'(rb) * 128'(4);
    if (lhs < rhs) return -1;
    if (lhs > rhs) return 1;
    return 0;
  endfunction

  function automatic relation_result_t classify_pair(
    input logic signed [CW-1:0] a1, b1, c1, a2, b2, c2
  );
    relation_result_t res;
    longint la1, lb1, lc1, la2, lb2, lc2;
    longint r1, r2, d, s, t;
    int inner, outer;
    la1 = a1; lb1 = b1; lc1 = c1;
    la2 = a2; lb2 = b2; lc2 = c2;
    r1 = la1 * la1 + lb1 * lb1 - 4 * lc1;
    r2 = la2 * la2 + lb2 * lb2 - 4 * lc2;
    d = (la2 - la1) * (la2 - la1) + (lb2 - lb1) * (lb2 - lb1);
    if (r1 < 0 || r2 < 0) begin
      res.rel = REL_INVALID;
    end else if (d == 0) begin
      res.rel = REL_CONCENTRIC;
    end else begin
      s = r1 + r2 - d;
      inner = 1;
      if (s >= 0) inner = -compare_square(s, r1, r2);
      if (inner == 0) begin
        res.rel = REL_INT_TANGENT;
      end else if (inner < 0) begin
        res.rel = REL_INSIDE;
      end else begin
        t = d - r1 - r2;
        outer = -1;
        if (t >= 0) outer = compare_square(t, r1, r2);
        if (outer < 0) res.rel = REL_TWO_POINTS;
        else if (outer == 0) res.rel = REL_EXT_TANGENT;
        else res.rel = REL_SEPARATE;
      end
    end
    res.c1x = CTR_W'(-la1);
    res.c1y = CTR_W'(-lb1);
    res.c2x = CTR_W'(-la2);
    res.c2y = CTR_W'(-lb2);
    res.r1 = SQ_W'(r1);
    res.r2 = SQ_W'(r2);
    res.d = SQ_W'(d);
    return res;
  endfunction

  task automatic add_pair(input int a1, b1, c1, a2, b2, c2, input bit drain);
    circle_pair_t pair;
    pair.a1 = CW'(a1); pair.b1 = CW'(b1); pair.c1 = CW'(c1);
    pair.a2 = CW'(a2); pair.b2 = CW'(b2); pair.c2 = CW'(c2);
    pair.drain_first = drain;
    pending_pairs.push_back(pair);
  endtask

  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (got !== want) begin
      $display("%0t %s mismatch: expected %0d, actual %0d", $time, name, $signed(want),
               $signed(got));
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expected_relations.push_back(classify_pair(coef_a1, coef_b1, coef_c1,
                                                   coef_a2, coef_b2, coef_c2));
      end
      if (!start || !busy) begin
        if (pending_pairs.size() != 0 &&
            !(pending_pairs[0].drain_first && expected_relations.size() != 0) &&
            $urandom_range(99) >= idle_pcts[(pairs_sent / 100) % 4]) begin
          next_pair = pending_pairs.pop_front();
          start <= 1'b1;
          coef_a1 <= next_pair.a1;
          coef_b1 <= next_pair.b1;
          coef_c1 <= next_pair.c1;
          coef_a2 <= next_pair.a2;
          coef_b2 <= next_pair.b2;
          coef_c2 <= next_pair.c2;
          pairs_sent <= pairs_sent + 1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_relations.size() == 0) begin
        $display("%0t result with no pending transfer: relation %0d", $time, relation);
        errors++;
      end else begin
        oldest_relation = expected_relations.pop_front();
        check_field("relation", oldest_relation.rel, relation);
        check_field("centre1_x", oldest_relation.c1x, centre1_x);
        check_field("centre1_y", oldest_relation.c1y, centre1_y);
        check_field("centre2_x", oldest_relation.c2x, centre2_x);
        check_field("centre2_y", oldest_relation.c2y, centre2_y);
        check_field("radius1_sq", oldest_relation.r1, radius1_sq);
        check_field("radius2_sq", oldest_relation.r2, radius2_sq);
        check_field("distance_sq", oldest_relation.d, distance_sq);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((start && !busy) || done) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t watchdog: no transfer for %0d cycles", $time, quiet_cycles);
        $display("FAIL two_circle_relation_classifier");
        $finish;
      end
    end
  end

  initial begin
    int kind, p1, q1, r1, r2, k, tx, ty, tl, dx, dy, d, lo, hi, tmp;
    int a1, b1, c1, a2, b2, c2;

    // field extremes
    add_pair(-32768, -32768, -32768, -32768, -32768, -32768, 1'b0);
    add_pair(32767, 32767, 32767, 32767, 32767, 32767, 1'b0);
    add_pair(-32768, -32768, -32768, 32767, 32767, 32767, 1'b0);
    add_pair(32767, -32768, 0, -32768, 32767, -32768, 1'b0);
    add_pair(0, 0, 0, 0, 0, 0, 1'b0);
    // every relation but invalid; tangent and inside pairs with circle one larger and then smaller
    add_pair(4, 6, -12, 4, 6, 5, 1'b0);
    add_pair(0, 0, -25, 4, 0, -5, 1'b0);
    add_pair(4, 0, -5, 0, 0, -25, 1'b0);
    add_pair(0, 0, -100, 2, 0, -3, 1'b0);
    add_pair(2, 0, -3, 0, 0, -100, 1'b0);
    add_pair(0, 0, -25, 12, 0, 11, 1'b0);
    add_pair(0, 0, -25, 20, 0, 75, 1'b0);
    add_pair(0, 0, -25, 40, 0, 375, 1'b0);
    add_pair(0, 0, -16, 6, 8, 16, 1'b0);
    // negative squared radius on either or both circles
    add_pair(0, 0, 1, 0, 0, -25, 1'b0);
    add_pair(0, 0, -25, 0, 0, 1, 1'b0);
    add_pair(2, 2, 32767, 4, 4, 32767, 1'b0);
    // point circles, then one pair whose second squared radius is negative
    add_pair(0, 0, 0, 10, 0, 0, 1'b0);
    add_pair(0, 0, 0, 2, 0, -24, 1'b0);
    add_pair(0, 0, 0, 20, 0, 75, 1'b0);
    add_pair(0, 0, 0, 2, 2, 2, 1'b0);
    add_pair(1, 3, -7, -5, 2, 9, 1'b0);

    for (int i = 0; i < RANDOM_PAIRS; i++) begin
      kind = $urandom_range(9);
      p1 = $urandom_range(80) - 40;
      q1 = $urandom_range(80) - 40;
      k = $urandom_range(4, 1);
      case ($urandom_range(3))
        0: begin tx = 0; ty = 1; tl = 1; end
        1: begin tx = 3; ty = 4; tl = 5; end
        2: begin tx = 5; ty = 12; tl = 13; end
        default: begin tx = 8; ty = 15; tl = 17; end
      endcase
      if ($urandom_range(1)) begin tmp = tx; tx = ty; ty = tmp; end
      dx = $urandom_range(1) ? tx * k : -tx * k;
      dy = $urandom_range(1) ? ty * k : -ty * k;
      d = tl * k;
      r1 = $urandom_range(40);
      r2 = $urandom_range(40);
      case (kind)
        0, 1: begin
          a1 = $urandom; b1 = $urandom; c1 = $urandom;
          a2 = $urandom; b2 = $urandom; c2 = $urandom;
        end
        2: begin
          a1 = $urandom_range(128) - 64; b1 = $urandom_range(128) - 64;
          c1 = $urandom_range(2000) - 1000;
          a2 = $urandom_range(128) - 64; b2 = $urandom_range(128) - 64;
          c2 = $urandom_range(2000) - 1000;
        end
        3: begin
          a1 = $urandom_range(128) - 64; b1 = $urandom_range(128) - 64;
          a2 = a1; b2 = b1;
          c1 = $urandom_range(2000) - 1000;
          c2 = $urandom_range(2000) - 1000;
        end
        4: begin
          a1 = $urandom_range(40) - 20; b1 = $urandom_range(40) - 20;
          a2 = $urandom_range(40) - 20; b2 = $urandom_range(40) - 20;
          c1 = $urandom_range(1) ? $urandom_range(32767, 200) : -$urandom_range(500);
          c2 = $urandom_range(32767, 200);
        end
        default: begin
          case (kind)
            5: r2 = (r1 >= d && $urandom_range(1)) ? r1 - d : r1 + d;
            6: r2 = r1 + d + $urandom_range(20, 1);
            7: begin
              lo = (r1 > d ? r1 - d : d - r1) + 1;
              hi = r1 + d - 1;
              r2 = (hi >= lo) ? $urandom_range(hi, lo) : r1 + d;
            end
            8: begin
              r1 = $urandom_range(d);
              r2 = d - r1;
            end
            default: begin
              r1 = $urandom_range(d / 2);
              r2 = $urandom_range(d - r1);
            end
          endcase
          a1 = 2 * p1; b1 = 2 * q1; c1 = p1 * p1 + q1 * q1 - r1 * r1;
          a2 = 2 * (p1 + dx); b2 = 2 * (q1 + dy);
          c2 = (p1 + dx) * (p1 + dx) + (q1 + dy) * (q1 + dy) - r2 * r2;
        end
      endcase
      if ($urandom_range(1))
        add_pair(a2, b2, c2, a1, b1, c1, i == 0 || $urandom_range(199) == 0);
      else
        add_pair(a1, b1, c1, a2, b2, c2, i == 0 || $urandom_range(199) == 0);
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    while (pending_pairs.size() != 0 || start || expected_relations.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("PASS two_circle_relation_classifier");
    end else begin
      $display("FAIL two_circle_relation_classifier");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+src
src/tcrc_pkg.sv
src/tcrc_sqprod.sv
src/two_circle_relation_classifier.sv
sim/tb_two_circle_relation_classifier.sv
